@@ hdl/gmt_pkg.sv @@
package gmt_pkg;

  localparam int GRID_ROWS     = 4;
  localparam int GRID_COLS     = 8;
  localparam int HISTORY_DEPTH = 16;
  localparam int NCELLS        = GRID_ROWS * GRID_COLS;

  localparam int IDX_W   = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int CNT_W   = $clog2(NCELLS + 1);
  localparam int GC_W    = $clog2(GRID_COLS + 1);
  localparam int GR_W    = $clog2(GRID_ROWS + 1);
  localparam int HD_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HC_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int TOT_W   = 32 + ((HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0);
  localparam int MEM_DEPTH = HISTORY_DEPTH * NCELLS;
  localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LIM_W   = 37;
  localparam int MASK_W  = 32;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(NCELLS - 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOT_CELLS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LENGTH = 3'd5;

  typedef struct packed {
    logic [IDX_W-1:0] cell_idx;
    logic [7:0]       diff;
    logic             in_grid;
    logic             last;
  } pix_t;

  typedef struct packed {
    logic              trigger;
    logic [5:0]        hot_count;
    logic [MASK_W-1:0] hot_mask;
    logic              adjacent_found;
    logic              global_change;
    logic [4:0]        history_fill;
  } res_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_SCAN,
    ST_DECIDE,
    ST_DROP_RD,
    ST_DROP_SUB,
    ST_PUSH,
    ST_DONE
  } back_state_t;

endpackage

@@ hdl/grid_motion_trigger.sv @@
// A pixel word is taken each cycle while in_ready is high and reaches the cell sums in
// the next cycle when idle. At frame end the block scans the 32 cells at one a cycle; a
// calm frame then drops old history frames until fewer than the history length remain
// and writes its sums into the ring. The result is registered after that evaluation.
// Pixels stall once the two-entry queue fills: in evaluation, or with an unread result.
// Reset is synchronous, active low; it clears positions, sums, totals and history count.
module grid_motion_trigger (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_prev_gray,
  input  logic [7:0]                       in_curr_gray,
  input  logic                             in_frame_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_trigger,
  output logic [5:0]                       out_hot_count,
  output logic [31:0]                      out_hot_mask,
  output logic                             out_adjacent_found,
  output logic                             out_global_change,
  output logic [4:0]                       out_history_fill,
  input  logic                             cfg_we,
  input  logic [gmt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gmt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [12:0] frame_width_r, cell_width_r;
  logic [11:0] cell_height_r, diff_threshold_r;
  logic [5:0]  max_hot_cells_r;
  logic [4:0]  history_length_r;

  logic          q_full, q_push, q_pop, q_valid;
  gmt_pkg::pix_t q_in, q_out;
  gmt_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= 13'd640;
      cell_width_r     <= 13'd80;
      cell_height_r    <= 12'd60;
      diff_threshold_r <= 12'd160;
      max_hot_cells_r  <= 6'd8;
      history_length_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        gmt_pkg::CFG_FRAME_WIDTH:    frame_width_r    <= cfg_data;
        gmt_pkg::CFG_CELL_WIDTH:     cell_width_r     <= cfg_data;
        gmt_pkg::CFG_CELL_HEIGHT:    cell_height_r    <= cfg_data[11:0];
        gmt_pkg::CFG_DIFF_THRESHOLD: diff_threshold_r <= cfg_data[11:0];
        gmt_pkg::CFG_MAX_HOT_CELLS:  max_hot_cells_r  <= cfg_data[5:0];
        gmt_pkg::CFG_HISTORY_LENGTH: history_length_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  gmt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_prev_gray (in_prev_gray),
    .in_curr_gray (in_curr_gray),
    .in_frame_end (in_frame_end),
    .frame_width  (frame_width_r),
    .cell_width   (cell_width_r),
    .cell_height  (cell_height_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  gmt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  gmt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .cell_width     (cell_width_r),
    .cell_height    (cell_height_r),
    .diff_threshold (diff_threshold_r),
    .max_hot_cells  (max_hot_cells_r),
    .history_length (history_length_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .res            (res)
  );

  assign out_trigger        = res.trigger;
  assign out_hot_count      = res.hot_count;
  assign out_hot_mask       = res.hot_mask;
  assign out_adjacent_found = res.adjacent_found;
  assign out_global_change  = res.global_change;
  assign out_history_fill   = res.history_fill;

  a_trigger_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger |-> out_adjacent_found && !out_global_change &&
                                 (out_hot_count > 6'd1))
    else $error("trigger without adjacent hot pair");

  a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(out_hot_mask) == 32'(out_hot_count)))
    else $error("hot count differs from mask");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_history_fill) <= gmt_pkg::HISTORY_DEPTH) &&
                  ((out_hot_count != 6'd0) || (out_history_fill != 5'd0)))
    else $error("history fill out of range");

endmodule

@@ hdl/gmt_front.sv @@
module gmt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_prev_gray,
  input  logic [7:0]         in_curr_gray,
  input  logic               in_frame_end,
  input  logic [12:0]        frame_width,
  input  logic [12:0]        cell_width,
  input  logic [11:0]        cell_height,
  input  logic               q_full,
  output logic               q_push,
  output gmt_pkg::pix_t      q_data
);

  logic [11:0] col_r, col_nxt;
  logic [10:0] row_r, row_nxt;
  logic [11:0] cx_r, cx_nxt;
  logic [10:0] ry_r, ry_nxt;
  logic [gmt_pkg::GC_W-1:0] gc_r, gc_nxt;
  logic [gmt_pkg::GR_W-1:0] gr_r, gr_nxt;
  logic [12:0] fw_eff, cw_eff;
  logic [11:0] ch_eff;
  logic        accept, row_end, in_grid;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign fw_eff   = (frame_width == 13'd0) ? 13'd1 :
                    (frame_width > 13'd4096) ? 13'd4096 : frame_width;
  assign cw_eff   = (cell_width == 13'd0) ? 13'd1 : cell_width;
  assign ch_eff   = (cell_height == 12'd0) ? 12'd1 : cell_height;
  assign in_grid  = (32'(gc_r) < gmt_pkg::GRID_COLS) && (32'(gr_r) < gmt_pkg::GRID_ROWS);
  assign row_end  = ({1'b0, col_r} + 13'd1) >= fw_eff;

  always_comb begin
    q_push          = accept;
    q_data.cell_idx = gmt_pkg::IDX_W'(32'(gr_r) * gmt_pkg::GRID_COLS + 32'(gc_r));
    q_data.diff     = (in_prev_gray > in_curr_gray) ? in_prev_gray - in_curr_gray
                                                    : in_curr_gray - in_prev_gray;
    q_data.in_grid  = in_grid;
    q_data.last     = in_frame_end;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    cx_nxt  = cx_r;
    ry_nxt  = ry_r;
    gc_nxt  = gc_r;
    gr_nxt  = gr_r;
    if (row_end) begin
      col_nxt = '0;
      cx_nxt  = '0;
      gc_nxt  = '0;
      if (row_r != 11'd2047) begin
        row_nxt = row_r + 11'd1;
        if (({1'b0, ry_r} + 12'd1) == ch_eff) begin
          ry_nxt = '0;
          if (32'(gr_r) < gmt_pkg::GRID_ROWS) begin
            gr_nxt = gr_r + 1'b1;
          end
        end else begin
          ry_nxt = ry_r + 11'd1;
        end
      end
    end else begin
      col_nxt = col_r + 12'd1;
      if (({1'b0, cx_r} + 13'd1) == cw_eff) begin
        cx_nxt = '0;
        if (32'(gc_r) < gmt_pkg::GRID_COLS) begin
          gc_nxt = gc_r + 1'b1;
        end
      end else begin
        cx_nxt = cx_r + 12'd1;
      end
    end
    if (in_frame_end) begin
      col_nxt = '0;
      row_nxt = '0;
      cx_nxt  = '0;
      ry_nxt  = '0;
      gc_nxt  = '0;
      gr_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cx_r  <= '0;
      ry_r  <= '0;
      gc_r  <= '0;
      gr_r  <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cx_r  <= cx_nxt;
      ry_r  <= ry_nxt;
      gc_r  <= gc_nxt;
      gr_r  <= gr_nxt;
    end
  end

endmodule

@@ hdl/gmt_queue.sv @@
module gmt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gmt_pkg::pix_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output gmt_pkg::pix_t pop_data
);

  gmt_pkg::pix_t ent_r [gmt_pkg::Q_DEPTH];
  logic [gmt_pkg::Q_PTR_W-1:0] wp_r, rp_r;
  logic [gmt_pkg::Q_CNT_W-1:0] cnt_r;
  logic do_push, do_pop;

  assign full      = (32'(cnt_r) == gmt_pkg::Q_DEPTH);
  assign not_empty = (cnt_r != '0);
  assign pop_data  = ent_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/gmt_back.sv @@
module gmt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  gmt_pkg::pix_t  q_data,
  output logic           q_pop,
  input  logic [12:0]    cell_width,
  input  logic [11:0]    cell_height,
  input  logic [11:0]    diff_threshold,
  input  logic [5:0]     max_hot_cells,
  input  logic [4:0]     history_length,
  output logic           out_valid,
  input  logic           out_ready,
  output gmt_pkg::res_t  res
);

  gmt_pkg::back_state_t state_r, state_nxt;

  logic [31:0]               sums_r [gmt_pkg::NCELLS];
  logic [gmt_pkg::TOT_W-1:0] tot_r  [gmt_pkg::NCELLS];
  logic [gmt_pkg::NCELLS-1:0] hotv_r;
  logic [gmt_pkg::CNT_W-1:0] hot_cnt_r, elev_cnt_r;
  logic [gmt_pkg::IDX_W-1:0] i_r;
  logic [gmt_pkg::HC_W-1:0]  cnt_r;
  logic [gmt_pkg::HD_W-1:0]  head_r;
  logic                      adj_r, glob_r;
  logic                      out_valid_r;
  gmt_pkg::res_t             res_r;
  logic [31:0]               mem [gmt_pkg::MEM_DEPTH];
  logic [31:0]               mem_q_r;
  logic [24:0]               prod_r;
  logic [gmt_pkg::LIM_W-1:0] limit_r;

  logic [12:0] cw_eff;
  logic [11:0] ch_eff;
  logic [gmt_pkg::HC_W-1:0] len_eff;
  logic [gmt_pkg::HD_W-1:0] head_inc, slot;
  logic [gmt_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [31:0] cur_sum;
  logic [32:0] acc_sum;
  logic        cell_hot, cell_elev, adj, glob, last_cell, out_free;
  logic        do_acc, do_scan, do_decide, do_rd, do_sub, do_push, do_done;
  logic [gmt_pkg::TOT_W:0] elev_lhs;
  gmt_pkg::res_t res_nxt;

  assign cw_eff    = (cell_width == 13'd0) ? 13'd1 : cell_width;
  assign ch_eff    = (cell_height == 12'd0) ? 12'd1 : cell_height;
  assign len_eff   = (history_length == 5'd0) ? gmt_pkg::HC_W'(1) :
                     (32'(history_length) > gmt_pkg::HISTORY_DEPTH) ?
                     gmt_pkg::HC_W'(gmt_pkg::HISTORY_DEPTH) :
                     gmt_pkg::HC_W'(history_length);
  assign last_cell = (i_r == gmt_pkg::LAST_CELL);
  assign out_free  = !out_valid_r || out_ready;
  assign cur_sum   = sums_r[i_r];
  assign acc_sum   = {1'b0, sums_r[q_data.cell_idx]} + 33'(q_data.diff);

  assign head_inc = (32'(head_r) + 1 >= gmt_pkg::HISTORY_DEPTH) ? '0 : head_r + 1'b1;
  assign slot     = gmt_pkg::HD_W'((32'(head_r) + 32'(cnt_r) >= gmt_pkg::HISTORY_DEPTH) ?
                    32'(head_r) + 32'(cnt_r) - gmt_pkg::HISTORY_DEPTH :
                    32'(head_r) + 32'(cnt_r));
  assign rd_addr  = gmt_pkg::ADDR_W'(32'(head_r) * gmt_pkg::NCELLS + 32'(i_r));
  assign wr_addr  = gmt_pkg::ADDR_W'(32'(slot) * gmt_pkg::NCELLS + 32'(i_r));

  assign cell_hot  = ({5'b0, cur_sum, 4'b0}) > {4'b0, limit_r};
  assign elev_lhs  = (gmt_pkg::TOT_W + 1)'(cur_sum) * (gmt_pkg::TOT_W + 1)'(cnt_r);
  assign cell_elev = elev_lhs >= {tot_r[i_r], 1'b0};

  always_comb begin
    adj = 1'b0;
    for (int r = 0; r < gmt_pkg::GRID_ROWS; r++) begin
      for (int c = 0; c < gmt_pkg::GRID_COLS; c++) begin
        if (c + 1 < gmt_pkg::GRID_COLS) begin
          if (hotv_r[r * gmt_pkg::GRID_COLS + c] && hotv_r[r * gmt_pkg::GRID_COLS + c + 1]) begin
            adj = 1'b1;
          end
        end
        if (r + 1 < gmt_pkg::GRID_ROWS) begin
          if (hotv_r[r * gmt_pkg::GRID_COLS + c] &&
              hotv_r[(r + 1) * gmt_pkg::GRID_COLS + c]) begin
            adj = 1'b1;
          end
        end
      end
    end
    glob = (cnt_r != '0) && (32'(elev_cnt_r) > gmt_pkg::NCELLS / 2);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gmt_pkg::ST_ACC: begin
        if (q_valid && q_data.last) begin
          state_nxt = gmt_pkg::ST_SCAN;
        end
      end
      gmt_pkg::ST_SCAN: begin
        if (last_cell) begin
          state_nxt = gmt_pkg::ST_DECIDE;
        end
      end
      gmt_pkg::ST_DECIDE: begin
        if (hot_cnt_r != '0) begin
          state_nxt = gmt_pkg::ST_DONE;
        end else if (cnt_r >= len_eff) begin
          state_nxt = gmt_pkg::ST_DROP_RD;
        end else begin
          state_nxt = gmt_pkg::ST_PUSH;
        end
      end
      gmt_pkg::ST_DROP_RD: begin
        state_nxt = gmt_pkg::ST_DROP_SUB;
      end
      gmt_pkg::ST_DROP_SUB: begin
        if (last_cell && ((cnt_r - 1'b1) < len_eff)) begin
          state_nxt = gmt_pkg::ST_PUSH;
        end else begin
          state_nxt = gmt_pkg::ST_DROP_RD;
        end
      end
      gmt_pkg::ST_PUSH: begin
        if (last_cell) begin
          state_nxt = gmt_pkg::ST_DONE;
        end
      end
      gmt_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = gmt_pkg::ST_ACC;
        end
      end
      default: state_nxt = gmt_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    do_acc    = 1'b0;
    do_scan   = 1'b0;
    do_decide = 1'b0;
    do_rd     = 1'b0;
    do_sub    = 1'b0;
    do_push   = 1'b0;
    do_done   = 1'b0;
    case (state_r)
      gmt_pkg::ST_ACC:      do_acc    = q_valid;
      gmt_pkg::ST_SCAN:     do_scan   = 1'b1;
      gmt_pkg::ST_DECIDE:   do_decide = 1'b1;
      gmt_pkg::ST_DROP_RD:  do_rd     = 1'b1;
      gmt_pkg::ST_DROP_SUB: do_sub    = 1'b1;
      gmt_pkg::ST_PUSH:     do_push   = 1'b1;
      gmt_pkg::ST_DONE:     do_done   = out_free;
      default:              do_acc    = 1'b0;
    endcase
  end

  assign q_pop = do_acc;

  always_comb begin
    res_nxt.trigger        = (hot_cnt_r > gmt_pkg::CNT_W'(1)) &&
                             (32'(hot_cnt_r) <= 32'(max_hot_cells)) && !glob_r && adj_r;
    res_nxt.hot_count      = (32'(hot_cnt_r) > 63) ? 6'd63 : 6'(hot_cnt_r);
    res_nxt.hot_mask       = '0;
    for (int k = 0; k < gmt_pkg::MASK_W; k++) begin
      if (k < gmt_pkg::NCELLS) begin
        res_nxt.hot_mask[k] = hotv_r[k];
      end
    end
    res_nxt.adjacent_found = adj_r;
    res_nxt.global_change  = glob_r;
    res_nxt.history_fill   = (32'(cnt_r) > 31) ? 5'd31 : 5'(cnt_r);
  end

  always_ff @(posedge clk) begin
    prod_r  <= 25'(cw_eff * ch_eff);
    limit_r <= gmt_pkg::LIM_W'(prod_r * diff_threshold);
    if (do_push) begin
      mem[wr_addr] <= sums_r[i_r];
    end
    if (do_rd) begin
      mem_q_r <= mem[rd_addr];
    end
    if (do_decide) begin
      adj_r  <= adj;
      glob_r <= glob;
    end
    if (do_done) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmt_pkg::ST_ACC;
      i_r         <= '0;
      cnt_r       <= '0;
      head_r      <= '0;
      hot_cnt_r   <= '0;
      elev_cnt_r  <= '0;
      hotv_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < gmt_pkg::NCELLS; k++) begin
        sums_r[k] <= '0;
        tot_r[k]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (do_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_acc && q_data.in_grid) begin
        sums_r[q_data.cell_idx] <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
      end
      if (do_scan) begin
        hotv_r[i_r] <= cell_hot;
        hot_cnt_r   <= hot_cnt_r + gmt_pkg::CNT_W'(cell_hot);
        elev_cnt_r  <= elev_cnt_r + gmt_pkg::CNT_W'(cell_elev);
        i_r         <= last_cell ? '0 : i_r + 1'b1;
      end
      if (do_sub) begin
        tot_r[i_r] <= tot_r[i_r] - gmt_pkg::TOT_W'(mem_q_r);
        i_r        <= last_cell ? '0 : i_r + 1'b1;
        if (last_cell) begin
          head_r <= head_inc;
          cnt_r  <= cnt_r - 1'b1;
        end
      end
      if (do_push) begin
        tot_r[i_r] <= tot_r[i_r] + gmt_pkg::TOT_W'(sums_r[i_r]);
        i_r        <= last_cell ? '0 : i_r + 1'b1;
        if (last_cell) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (do_done) begin
        hot_cnt_r   <= '0;
        elev_cnt_r  <= '0;
        for (int k = 0; k < gmt_pkg::NCELLS; k++) begin
          sums_r[k] <= '0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

@@ tb/grid_motion_trigger_tb.sv @@
`timescale 1ns / 100ps

module grid_motion_trigger_tb;

  typedef struct packed {
    logic [7:0] prev_gray;
    logic [7:0] curr_gray;
    logic       frame_end;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_prev_gray = '0;
  logic [7:0] in_curr_gray = '0;
  logic in_frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_trigger;
  logic [5:0] out_hot_count;
  logic [31:0] out_hot_mask;
  logic out_adjacent_found;
  logic out_global_change;
  logic [4:0] out_history_fill;
  logic cfg_we = 1'b0;
  logic [gmt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gmt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  grid_motion_trigger DUT (.*);

  always #4 clk = ~clk;

  // Predictor state.
  int unsigned fw_reg, cw_reg, ch_reg, thr_reg, maxhot_reg, histlen_reg;
  int unsigned col_pos, row_pos;
  longint unsigned sums[gmt_pkg::NCELLS];
  longint unsigned calm[gmt_pkg::HISTORY_DEPTH][gmt_pkg::NCELLS];
  longint unsigned totals[gmt_pkg::NCELLS];
  int unsigned hist_count, hist_head;

  pixel_t pending_pixels[$];
  gmt_pkg::res_t expected_results[$];
  int mismatches = 0;
  bit quiet_out = 1'b0;
  bit quiet_in = 1'b0;
  bit stall_out = 1'b0;
  bit drain_hold = 1'b0;
  int idle_pct = 16;

  function automatic int unsigned nz(int unsigned v);
    return v == 0 ? 1 : v;
  endfunction

  function automatic void queue_pixel(pixel_t p);
    pending_pixels.insert(pending_pixels.size(), p);
  endfunction

  task automatic predict_reset();
    fw_reg = 640; cw_reg = 80; ch_reg = 60; thr_reg = 160; maxhot_reg = 8; histlen_reg = 16;
    col_pos = 0; row_pos = 0; hist_count = 0; hist_head = 0;
    for (int i = 0; i < gmt_pkg::NCELLS; i++) begin
      sums[i] = 0; totals[i] = 0;
    end
  endtask

  task automatic push_calm_frame();
    int unsigned len, slot;
    len = nz(histlen_reg);
    if (len > gmt_pkg::HISTORY_DEPTH) len = gmt_pkg::HISTORY_DEPTH;
    while (hist_count >= len) begin
      for (int i = 0; i < gmt_pkg::NCELLS; i++) totals[i] -= calm[hist_head][i];
      hist_head = (hist_head + 1) % gmt_pkg::HISTORY_DEPTH;
      hist_count--;
    end
    slot = (hist_head + hist_count) % gmt_pkg::HISTORY_DEPTH;
    for (int i = 0; i < gmt_pkg::NCELLS; i++) begin
      calm[slot][i] = sums[i];
      totals[i] += sums[i];
    end
    hist_count++;
  endtask

  task automatic predict_pixel(pixel_t p);
    int unsigned cw, ch, fw, gc, gr, d, hot, elevated, idx;
    longint unsigned lim;
    bit hotv[gmt_pkg::NCELLS];
    bit adj, glob;
    gmt_pkg::res_t r;
    cw = nz(cw_reg); ch = nz(ch_reg); fw = nz(fw_reg);
    if (fw > 4096) fw = 4096;
    gc = col_pos / cw; gr = row_pos / ch;
    d = 32'(p.prev_gray > p.curr_gray ? p.prev_gray - p.curr_gray
                                      : p.curr_gray - p.prev_gray);
    if (gc < gmt_pkg::GRID_COLS && gr < gmt_pkg::GRID_ROWS) begin
      idx = gr * gmt_pkg::GRID_COLS + gc;
      sums[idx] = (sums[idx] + d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sums[idx] + d;
    end
    if (col_pos + 1 >= fw) begin
      col_pos = 0;
      if (row_pos < 2047) row_pos++;
    end else col_pos++;
    if (!p.frame_end) return;
    lim = longint'(thr_reg) * cw * ch;
    hot = 0; adj = 0; glob = 0; elevated = 0;
    r = '0;
    for (int i = 0; i < gmt_pkg::NCELLS; i++) begin
      hotv[i] = (sums[i] << 4) > lim;
      if (hotv[i]) begin
        hot++;
        if (i < 32) r.hot_mask[i] = 1'b1;
      end
    end
    for (int rr = 0; rr < gmt_pkg::GRID_ROWS; rr++)
      for (int c = 0; c < gmt_pkg::GRID_COLS; c++) begin
        idx = rr * gmt_pkg::GRID_COLS + c;
        if (hotv[idx]) begin
          if (c + 1 < gmt_pkg::GRID_COLS && hotv[idx + 1]) adj = 1;
          if (rr + 1 < gmt_pkg::GRID_ROWS && hotv[idx + gmt_pkg::GRID_COLS]) adj = 1;
        end
      end
    if (hist_count > 0) begin
      for (int i = 0; i < gmt_pkg::NCELLS; i++)
        if (sums[i] * hist_count >= 2 * totals[i]) elevated++;
      glob = elevated > gmt_pkg::NCELLS / 2;
    end
    r.trigger = hot > 1 && hot <= maxhot_reg && !glob && adj;
    if (hot == 0) push_calm_frame();
    r.hot_count = 6'(hot > 63 ? 63 : hot);
    r.adjacent_found = adj;
    r.global_change = glob;
    r.history_fill = 5'(hist_count > 31 ? 31 : hist_count);
    expected_results.insert(expected_results.size(), r);
    for (int i = 0; i < gmt_pkg::NCELLS; i++) sums[i] = 0;
    col_pos = 0; row_pos = 0;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_pixel(pixel_t'{in_prev_gray, in_curr_gray, in_frame_end});
    end
    if (!in_valid || in_ready) begin
      if (pending_pixels.size() > 0 && !drain_hold &&
          (quiet_in || $urandom_range(99) >= idle_pct)) begin
        pixel_t p;
        p = pending_pixels[0];
        pending_pixels.delete(0);
        in_valid <= 1'b1;
        in_prev_gray <= p.prev_gray;
        in_curr_gray <= p.curr_gray;
        in_frame_end <= p.frame_end;
      end else in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      gmt_pkg::res_t got, want;
      got = gmt_pkg::res_t'{out_trigger, out_hot_count, out_hot_mask, out_adjacent_found,
                            out_global_change, out_history_fill};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
    out_ready <= !stall_out && (quiet_out || $urandom_range(99) >= idle_pct);
  end

  task automatic write_reg(logic [gmt_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[gmt_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gmt_pkg::CFG_FRAME_WIDTH: fw_reg = val & 13'h1FFF;
      gmt_pkg::CFG_CELL_WIDTH: cw_reg = val & 13'h1FFF;
      gmt_pkg::CFG_CELL_HEIGHT: ch_reg = val & 12'hFFF;
      gmt_pkg::CFG_DIFF_THRESHOLD: thr_reg = val & 12'hFFF;
      gmt_pkg::CFG_MAX_HOT_CELLS: maxhot_reg = val & 6'h3F;
      gmt_pkg::CFG_HISTORY_LENGTH: histlen_reg = val & 5'h1F;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic add_frame(int unsigned npix, int unsigned mode);
    pixel_t p;
    for (int unsigned k = 0; k < npix; k++) begin
      p.prev_gray = 8'($urandom_range(255));
      case (mode)
        0: p.curr_gray = p.prev_gray;
        1: p.curr_gray = ($urandom_range(3) == 0) ? ~p.prev_gray : p.prev_gray;
        default: p.curr_gray = 8'($urandom_range(255));
      endcase
      p.frame_end = (k == npix - 1);
      queue_pixel(p);
    end
  endtask

  task automatic small_grid(int unsigned fw, int unsigned cw, int unsigned ch,
                            int unsigned thr, int unsigned mh, int unsigned hl);
    write_reg(gmt_pkg::CFG_FRAME_WIDTH, fw);
    write_reg(gmt_pkg::CFG_CELL_WIDTH, cw);
    write_reg(gmt_pkg::CFG_CELL_HEIGHT, ch);
    write_reg(gmt_pkg::CFG_DIFF_THRESHOLD, thr);
    write_reg(gmt_pkg::CFG_MAX_HOT_CELLS, mh);
    write_reg(gmt_pkg::CFG_HISTORY_LENGTH, hl);
  endtask

  initial begin
    predict_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme values, frame end as first pixel, calm and busy frames.
    small_grid(8, 1, 1, 0, 32, 1);
    queue_pixel(pixel_t'{8'h00, 8'hFF, 1'b0});
    queue_pixel(pixel_t'{8'hFF, 8'h00, 1'b0});
    queue_pixel(pixel_t'{8'h00, 8'h00, 1'b1});
    queue_pixel(pixel_t'{8'hAA, 8'h55, 1'b1});
    add_frame(32, 0);
    add_frame(32, 2);
    add_frame(40, 2);
    wait_idle();
    small_grid(0, 0, 0, 4095, 0, 0);
    add_frame(12, 2);
    add_frame(3, 0);
    wait_idle();
    small_grid(8191, 8191, 4095, 8, 63, 31);
    add_frame(6, 2);
    add_frame(2, 0);
    wait_idle();

    // Random frames on small grids; calm frames build a baseline.
    for (int ph = 0; ph < 6; ph++) begin
      small_grid($urandom_range(16, 4), $urandom_range(2, 1), $urandom_range(2, 1),
                 $urandom_range(1500), $urandom_range(32), $urandom_range(17));
      quiet_in = (ph == 2);
      quiet_out = (ph == 2);
      for (int f = 0; f < 8; f++) add_frame($urandom_range(14, 1), $urandom_range(2));
      if (ph == 3) begin
        stall_out = 1'b1;
        repeat (400) @(posedge clk);
        stall_out = 1'b0;
      end
      wait_idle();
    end

    // Sender pauses until every result has come, then continues.
    add_frame(10, 2);
    add_frame(10, 2);
    while (pending_pixels.size() > 10) @(posedge clk);
    drain_hold = 1'b1;
    while (in_valid || expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    drain_hold = 1'b0;
    wait_idle();

    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule

@@ sim.f @@
hdl/gmt_pkg.sv
hdl/gmt_front.sv
hdl/gmt_queue.sv
hdl/gmt_back.sv
hdl/grid_motion_trigger.sv
tb/grid_motion_trigger_tb.sv
